// File: rtl/cgb_pkg.sv
// ----------------------------------------------------------------------------
// cgb_pkg
// Shared types and constants of the color gradient with brightness unit.
// ----------------------------------------------------------------------------
package cgb_pkg;

    localparam int ANCHOR_COUNT = 7;
    localparam int SEG_COUNT    = ANCHOR_COUNT - 1;
    localparam int CHAN_COUNT   = 3;
    localparam int CHAN_W       = 8;
    localparam int POS_W        = 10;
    localparam int BRI_W        = 7;
    localparam int SEG_W        = 3;
    localparam int BRIGHT_FLOOR = 20;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [SEG_W-1:0]  t_seg;
    typedef logic [POS_W-1:0]  t_pos;

    typedef struct packed {
        t_chan base;
        t_chan mag;
        logic  neg;
    } t_chan_delta;

    typedef t_chan_delta [CHAN_COUNT-1:0] t_delta_vec;

    typedef struct packed {
        t_seg seg;
        t_pos frac;
    } t_seg_pos;

    localparam t_chan ANCHOR_TAB [ANCHOR_COUNT][CHAN_COUNT] = '{
        '{8'hFF, 8'h00, 8'h00},
        '{8'h73, 8'h8C, 8'h00},
        '{8'h00, 8'hFE, 8'h01},
        '{8'h00, 8'h5C, 8'hA3},
        '{8'h13, 8'h00, 8'hEC},
        '{8'h6C, 8'h00, 8'h93},
        '{8'hFF, 8'h00, 8'h00}
    };

endpackage

// File: rtl/cgb_const_div.sv
// ----------------------------------------------------------------------------
// cgb_const_div
// Unsigned division by a constant through a rounded-up reciprocal multiply.
// ----------------------------------------------------------------------------
module cgb_const_div #(
    parameter int DIVISOR = 100,
    parameter int N_BITS  = 18,
    parameter int Q_BITS  = 8
) (
    input  logic [N_BITS-1:0] i_num,
    output logic [Q_BITS-1:0] o_quo
);

    // The quotient is exact below two to the N_BITS while it fits Q_BITS.
    localparam int L_BITS = $clog2(DIVISOR);
    localparam int SH     = N_BITS + L_BITS;
    localparam int M_BITS = N_BITS + 2;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int PROD_W = (N_BITS + M_BITS > SH + Q_BITS) ?
                            N_BITS + M_BITS : SH + Q_BITS;

    logic [PROD_W-1:0] prod;

    assign prod  = PROD_W'(i_num) * PROD_W'(M_BITS'(RECIP));
    assign o_quo = prod[SH +: Q_BITS];

endmodule

// File: rtl/cgb_seg_sel.sv
// ----------------------------------------------------------------------------
// cgb_seg_sel
// Saturates the hue position, finds its segment and offset, and looks up the
// anchor colors and the per-channel step toward the next anchor.
// ----------------------------------------------------------------------------
module cgb_seg_sel #(
    parameter int SEGMENT_LENGTH = 100
) (
    input  cgb_pkg::t_pos       i_position,
    output cgb_pkg::t_seg_pos   o_sel,
    output cgb_pkg::t_delta_vec o_delta
);

    import cgb_pkg::*;

    localparam int POS_LIMIT = SEGMENT_LENGTH * SEG_COUNT;
    localparam int POS_MAX   = (1 << POS_W) - 1;
    localparam int POS_SAT   = (POS_LIMIT < POS_MAX) ? POS_LIMIT : POS_MAX;

    t_pos  pos_sat;
    t_pos  base_pos;
    t_seg  seg;
    t_seg  seg_next;
    t_chan anc_a;
    t_chan anc_b;

    assign pos_sat = (i_position > POS_W'(POS_SAT)) ? POS_W'(POS_SAT) : i_position;

    always_comb begin
        seg      = '0;
        base_pos = '0;
        for (int k = 1; k < SEG_COUNT; k++) begin
            if (32'(pos_sat) >= 32'(k * SEGMENT_LENGTH)) begin
                seg      = SEG_W'(k);
                base_pos = POS_W'(k * SEGMENT_LENGTH);
            end
        end
    end

    assign seg_next   = seg + SEG_W'(1);
    assign o_sel.seg  = seg;
    assign o_sel.frac = pos_sat - base_pos;

    always_comb begin
        anc_a   = '0;
        anc_b   = '0;
        o_delta = '0;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            anc_a           = ANCHOR_TAB[seg][c];
            anc_b           = ANCHOR_TAB[seg_next][c];
            o_delta[c].base = anc_a;
            o_delta[c].neg  = (anc_b < anc_a);
            o_delta[c].mag  = (anc_b < anc_a) ? (anc_a - anc_b) : (anc_b - anc_a);
        end
    end

endmodule

// File: rtl/color_gradient_with_brightness_unit.sv
// ----------------------------------------------------------------------------
// color_gradient_with_brightness_unit
// Maps a hue position onto a seven-anchor RGB gradient and scales the color
// by a brightness with a floor of twenty percent, or to zero levels when off.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while o_ready is high, through a
// six-stage pipeline: the segment lookup with the brightness scaling, the
// step times the segment offset with the division of the brightness, the
// reciprocal multiply of the interpolation, the add and clamp of each
// channel, the color times the effective brightness and the final reciprocal
// multiply. There is no state between transactions. When the output is
// stalled, full stages hold their contents and empty stages still fill, so
// o_ready falls only once all six stages hold data.
module color_gradient_with_brightness_unit #(
    parameter int BRIGHTNESS_MAX = 100,
    parameter int SEGMENT_LENGTH = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [9:0]            i_position,
    input  logic [6:0]            i_brightness,
    input  logic                  i_switch_on,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_red_level,
    output logic [7:0]            o_green_level,
    output logic [7:0]            o_blue_level,
    output logic [15:0]           o_packed_565
);

    import cgb_pkg::*;

    localparam int SCALE      = BRIGHTNESS_MAX - BRIGHT_FLOOR;
    localparam int SCALE_W    = $clog2(SCALE + 1);
    localparam int BNUM_W     = BRI_W + SCALE_W;
    localparam int EFF_W      = $clog2(BRIGHTNESS_MAX + 1);
    localparam int LERP_NUM_W = CHAN_W + POS_W;
    localparam int LVL_NUM_W  = CHAN_W + EFF_W;
    localparam int BRI_MAX    = (1 << BRI_W) - 1;
    localparam int BRI_SAT    = (BRIGHTNESS_MAX < BRI_MAX) ? BRIGHTNESS_MAX : BRI_MAX;

    logic en1, en2, en3, en4, en5, en6;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_o_valid;

    t_seg_pos   sel;
    t_delta_vec n_delta;
    logic [BRI_W-1:0] bri_sat;

    t_pos        r1_frac;
    t_delta_vec  r1_delta;
    logic [BNUM_W-1:0] r1_bnum;
    logic        r1_on;

    logic [LERP_NUM_W-1:0] r2_prod [CHAN_COUNT];
    t_chan       r2_base [CHAN_COUNT];
    logic        r2_neg [CHAN_COUNT];
    logic [EFF_W-1:0] r2_eff;
    logic        r2_on;
    logic [BRI_W-1:0] eff_quo;

    t_chan       n_quo [CHAN_COUNT];
    t_chan       r3_quo [CHAN_COUNT];
    t_chan       r3_base [CHAN_COUNT];
    logic        r3_neg [CHAN_COUNT];
    logic [EFF_W-1:0] r3_eff;
    logic        r3_on;

    logic signed [CHAN_W+1:0] n_sum [CHAN_COUNT];
    t_chan       n_ch [CHAN_COUNT];
    t_chan       r4_ch [CHAN_COUNT];
    logic [EFF_W-1:0] r4_eff;
    logic        r4_on;

    logic [LVL_NUM_W-1:0] r5_prod [CHAN_COUNT];
    t_chan       r5_ch [CHAN_COUNT];
    logic        r5_on;

    t_chan       n_lvl [CHAN_COUNT];
    t_chan       r6_ch [CHAN_COUNT];
    t_chan       r6_lvl [CHAN_COUNT];

    assign en6     = !r_o_valid || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_o_valid <= r_v5;
        end
    end

    cgb_seg_sel #(
        .SEGMENT_LENGTH(SEGMENT_LENGTH)
    ) u_seg_sel (
        .i_position(i_position),
        .o_sel     (sel),
        .o_delta   (n_delta)
    );

    assign bri_sat = (i_brightness > BRI_W'(BRI_SAT)) ? BRI_W'(BRI_SAT) : i_brightness;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_frac  <= sel.frac;
            r1_delta <= n_delta;
            r1_bnum  <= BNUM_W'(bri_sat) * BNUM_W'(SCALE);
            r1_on    <= i_switch_on;
        end
    end

    cgb_const_div #(
        .DIVISOR(BRIGHTNESS_MAX),
        .N_BITS (BNUM_W),
        .Q_BITS (BRI_W)
    ) u_eff_div (
        .i_num(r1_bnum),
        .o_quo(eff_quo)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
                r2_prod[c] <= LERP_NUM_W'(r1_delta[c].mag) * LERP_NUM_W'(r1_frac);
                r2_base[c] <= r1_delta[c].base;
                r2_neg[c]  <= r1_delta[c].neg;
            end
            r2_eff <= EFF_W'(eff_quo) + EFF_W'(BRIGHT_FLOOR);
            r2_on  <= r1_on;
        end
    end

    for (genvar g = 0; g < CHAN_COUNT; g++) begin : g_lerp_div
        cgb_const_div #(
            .DIVISOR(SEGMENT_LENGTH),
            .N_BITS (LERP_NUM_W),
            .Q_BITS (CHAN_W)
        ) u_lerp_div (
            .i_num(r2_prod[g]),
            .o_quo(n_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
                r3_quo[c]  <= n_quo[c];
                r3_base[c] <= r2_base[c];
                r3_neg[c]  <= r2_neg[c];
            end
            r3_eff <= r2_eff;
            r3_on  <= r2_on;
        end
    end

    always_comb begin
        for (int c = 0; c < CHAN_COUNT; c++) begin
            n_sum[c] = r3_neg[c] ?
                       $signed({2'b00, r3_base[c]}) - $signed({2'b00, r3_quo[c]}) :
                       $signed({2'b00, r3_base[c]}) + $signed({2'b00, r3_quo[c]});
            if (n_sum[c] < 0) begin
                n_ch[c] = '0;
            end else if (n_sum[c] > $signed((CHAN_W+2)'(255))) begin
                n_ch[c] = '1;
            end else begin
                n_ch[c] = n_sum[c][CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
                r4_ch[c] <= n_ch[c];
            end
            r4_eff <= r3_eff;
            r4_on  <= r3_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
                r5_prod[c] <= LVL_NUM_W'(r4_ch[c]) * LVL_NUM_W'(r4_eff);
                r5_ch[c]   <= r4_ch[c];
            end
            r5_on <= r4_on;
        end
    end

    for (genvar g = 0; g < CHAN_COUNT; g++) begin : g_level_div
        cgb_const_div #(
            .DIVISOR(BRIGHTNESS_MAX),
            .N_BITS (LVL_NUM_W),
            .Q_BITS (CHAN_W)
        ) u_level_div (
            .i_num(r5_prod[g]),
            .o_quo(n_lvl[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
                r6_ch[c]  <= r5_ch[c];
                r6_lvl[c] <= r5_on ? n_lvl[c] : '0;
            end
        end
    end

    assign o_red         = r6_ch[CH_RED];
    assign o_green       = r6_ch[CH_GREEN];
    assign o_blue        = r6_ch[CH_BLUE];
    assign o_red_level   = r6_lvl[CH_RED];
    assign o_green_level = r6_lvl[CH_GREEN];
    assign o_blue_level  = r6_lvl[CH_BLUE];
    assign o_packed_565  = {r6_ch[CH_RED][7:3], r6_ch[CH_GREEN][7:2], r6_ch[CH_BLUE][7:3]};

    a_level_not_above_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red_level <= o_red) && (o_green_level <= o_green) &&
                    (o_blue_level <= o_blue))
        else $error("Drive level exceeds the raw color.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_o_valid && !i_ready)
        else $error("Input stalled while the pipeline has an empty stage.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

endmodule

// File: test/color_gradient_with_brightness_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_gradient_with_brightness_unit_tb
// Sends hue positions, brightness values and on/off flags through the
// gradient unit with random gaps on both handshakes. Each accepted
// transaction is predicted in the bench, and every result is compared
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module color_gradient_with_brightness_unit_tb;

    import cgb_pkg::*;

    localparam int BRI_MAX     = 100;
    localparam int SEG_LEN     = 100;
    localparam int POS_LIMIT   = SEG_LEN * SEG_COUNT;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] HUE_ANCHORS [ANCHOR_COUNT][CHAN_COUNT] = '{
        '{8'hFF, 8'h00, 8'h00},
        '{8'h73, 8'h8C, 8'h00},
        '{8'h00, 8'hFE, 8'h01},
        '{8'h00, 8'h5C, 8'hA3},
        '{8'h13, 8'h00, 8'hEC},
        '{8'h6C, 8'h00, 8'h93},
        '{8'hFF, 8'h00, 8'h00}
    };

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  red_lvl;
        logic [7:0]  green_lvl;
        logic [7:0]  blue_lvl;
        logic [15:0] rgb565;
    } t_gradient;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [9:0]  i_position;
    logic [6:0]  i_brightness;
    logic        i_switch_on;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_red_level;
    logic [7:0]  o_green_level;
    logic [7:0]  o_blue_level;
    logic [15:0] o_packed_565;

    t_gradient pending_colors [$];
    int        mismatch_cnt;
    int        sent_cnt;
    int        checked_cnt;
    int        off_cnt;
    int        cycle_cnt;
    bit        idle_on;

    color_gradient_with_brightness_unit #(
        .BRIGHTNESS_MAX(BRI_MAX),
        .SEGMENT_LENGTH(SEG_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_position    (i_position),
        .i_brightness  (i_brightness),
        .i_switch_on   (i_switch_on),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_packed_565  (o_packed_565)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_gradient gradient_color(input logic [9:0] pos_in,
                                                 input logic [6:0] bri_in,
                                                 input logic on);
        int        pos;
        int        seg;
        int        frac;
        int        bri;
        int        eff;
        int        d;
        int        v;
        int        chan [CHAN_COUNT];
        int        lvl [CHAN_COUNT];
        t_gradient res;
        pos = int'(pos_in);
        if (pos > POS_LIMIT) pos = POS_LIMIT;
        seg = pos / SEG_LEN;
        if (seg > SEG_COUNT - 1) seg = SEG_COUNT - 1;
        frac = pos - seg * SEG_LEN;
        bri = int'(bri_in);
        if (bri > BRI_MAX) bri = BRI_MAX;
        eff = BRIGHT_FLOOR + bri * (BRI_MAX - BRIGHT_FLOOR) / BRI_MAX;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            d = int'(HUE_ANCHORS[seg+1][c]) - int'(HUE_ANCHORS[seg][c]);
            v = int'(HUE_ANCHORS[seg][c]) + (d * frac) / SEG_LEN;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            chan[c] = v;
            lvl[c] = on ? ((v * eff / BRI_MAX) & 8'hFF) : 0;
        end
        res.red       = 8'(chan[CH_RED]);
        res.green     = 8'(chan[CH_GREEN]);
        res.blue      = 8'(chan[CH_BLUE]);
        res.red_lvl   = 8'(lvl[CH_RED]);
        res.green_lvl = 8'(lvl[CH_GREEN]);
        res.blue_lvl  = 8'(lvl[CH_BLUE]);
        res.rgb565    = 16'(((chan[CH_RED] & 8'hF8) << 8) |
                            ((chan[CH_GREEN] & 8'hFC) << 3) | (chan[CH_BLUE] >> 3));
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic send_color(input logic [9:0] pos, input logic [6:0] bri, input logic on);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_position   <= pos;
        i_brightness <= bri;
        i_switch_on  <= on;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_colors.push_back(gradient_color(pos, bri, on));
        sent_cnt++;
        if (!on) off_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_gradient want;
        if (i_rst_n && o_valid && i_ready) begin
            checked_cnt++;
            if (pending_colors.size() == 0) begin
                report_mismatch("result transaction with no prediction pending");
            end else begin
                want = pending_colors.pop_front();
                check_field("red", int'(o_red), int'(want.red));
                check_field("green", int'(o_green), int'(want.green));
                check_field("blue", int'(o_blue), int'(want.blue));
                check_field("red_level", int'(o_red_level), int'(want.red_lvl));
                check_field("green_level", int'(o_green_level), int'(want.green_lvl));
                check_field("blue_level", int'(o_blue_level), int'(want.blue_lvl));
                check_field("packed_565", int'(o_packed_565), int'(want.rgb565));
            end
        end
    end

    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 8) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("Mismatches found");
        $finish;
    end

    task automatic test_position_extremes();
        send_color(10'd0, 7'd100, 1'b1);
        send_color(10'd1, 7'd100, 1'b1);
        send_color(10'd599, 7'd100, 1'b1);
        send_color(10'd600, 7'd100, 1'b1);
        send_color(10'd601, 7'd100, 1'b1);
        send_color(10'd1023, 7'd100, 1'b1);
    endtask

    task automatic test_segment_edges();
        for (int k = 1; k < SEG_COUNT; k++) begin
            send_color(10'(k * SEG_LEN), 7'd50, 1'b1);
        end
        send_color(10'd150, 7'd75, 1'b1);
        send_color(10'd450, 7'd25, 1'b1);
    endtask

    task automatic test_brightness_extremes();
        send_color(10'd0, 7'd0, 1'b1);
        send_color(10'd250, 7'd1, 1'b1);
        send_color(10'd350, 7'd99, 1'b1);
        send_color(10'd0, 7'd100, 1'b1);
        send_color(10'd550, 7'd101, 1'b1);
        send_color(10'd320, 7'd127, 1'b1);
    endtask

    task automatic test_light_off();
        send_color(10'd300, 7'd100, 1'b0);
        send_color(10'd600, 7'd127, 1'b0);
        send_color(10'd1023, 7'd0, 1'b0);
    endtask

    task automatic test_random_colors(input int count);
        logic [9:0] pos;
        logic [6:0] bri;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            pos = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, POS_LIMIT));
            bri = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, BRI_MAX));
            send_color(pos, bri, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        mismatch_cnt = 0;
        sent_cnt     = 0;
        checked_cnt  = 0;
        off_cnt      = 0;
        idle_on      = 1'b1;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_position   = '0;
        i_brightness = '0;
        i_switch_on  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_position_extremes();
        test_segment_edges();
        test_brightness_extremes();
        test_light_off();
        test_random_colors(1000);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d transactions (%0d with the light off), checked %0d results.",
                 sent_cnt, off_cnt, checked_cnt);
        $display("Covered all six segments, saturated positions and brightness values.");
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: color_gradient_with_brightness_unit.f
rtl/cgb_pkg.sv
rtl/cgb_const_div.sv
rtl/cgb_seg_sel.sv
rtl/color_gradient_with_brightness_unit.sv
test/color_gradient_with_brightness_unit_tb.sv
